FILE: rtl/srdp_pkg.sv
package srdp_pkg;

  localparam int TableSize = 1024;
  localparam int AddrW     = 10;
  localparam int MaxElem   = 256;
  localparam int ElemIdxW  = 8;
  localparam int CountW    = 9;
  localparam int ValueW    = 15;
  localparam int CheckW    = 11;
  localparam int DispW     = 12;

  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic [CheckW-1:0] CheckEmpty = {CheckW{1'b1}};

  typedef struct packed {
    logic [1:0]        cmd;
    logic [AddrW-1:0]  column;
    logic [ValueW-1:0] value;
    logic              last;
  } item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctrl_t;

  typedef struct packed {
    logic [CheckW-1:0] disp;
    logic              ovf;
    logic [AddrW-1:0]  highest;
    logic [ValueW-1:0] rvalue;
    logic [CheckW-1:0] rcheck;
    logic              is_read;
  } result_t;

endpackage

FILE: rtl/srdp_front.sv
module srdp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  srdp_pkg::item_t      item_i,
  input  srdp_pkg::back_ctrl_t ctrl_i,
  output logic                 q_valid_o,
  output srdp_pkg::item_t      q_item_o
);

  srdp_pkg::item_t fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, push, known_cmd;

  assign stall_o   = (cnt_q == 2'd2) || ctrl_i.clearing;
  assign accept    = valid_i && !stall_o;
  // drop the unused command code here
  assign known_cmd = item_i.cmd inside {srdp_pkg::CmdLoad, srdp_pkg::CmdRead,
                                        srdp_pkg::CmdClear};
  assign push      = accept && known_cmd;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = ctrl_i.pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, ctrl_i.pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/srdp_engine.sv
module srdp_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  srdp_pkg::item_t      q_item_i,
  output srdp_pkg::back_ctrl_t ctrl_o,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output srdp_pkg::result_t    res_o
);

  localparam logic [3:0] SClear  = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SStart  = 4'd2;
  localparam logic [3:0] SJTest  = 4'd3;
  localparam logic [3:0] SERead  = 4'd4;
  localparam logic [3:0] SCRead  = 4'd5;
  localparam logic [3:0] SCTest  = 4'd6;
  localparam logic [3:0] SWRead  = 4'd7;
  localparam logic [3:0] SWrite  = 4'd8;
  localparam logic [3:0] SLfRead = 4'd9;
  localparam logic [3:0] SLfTest = 4'd10;
  localparam logic [3:0] SRData  = 4'd11;
  localparam logic [3:0] SResult = 4'd12;

  localparam int AW = srdp_pkg::AddrW;
  localparam int CW = srdp_pkg::CountW;
  localparam int DW = srdp_pkg::DispW;
  localparam logic signed [DW-1:0] TableLimit = DW'(srdp_pkg::TableSize);
  localparam logic [AW-1:0] LastAddr = AW'(srdp_pkg::TableSize - 1);

  logic [3:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d, k_q, k_d;
  logic [AW-1:0]        min_q, min_d, max_q, max_d;
  logic [AW-1:0]        lowest_q, lowest_d, highest_q, highest_d, clr_q, clr_d;
  logic signed [DW-1:0] j_q, j_d, reach, loc_w;
  srdp_pkg::result_t    res_q, res_d;

  logic [AW-1:0]                  ebuf_col [srdp_pkg::MaxElem];
  logic [srdp_pkg::ValueW-1:0]    ebuf_val [srdp_pkg::MaxElem];
  logic [srdp_pkg::CheckW-1:0]    check_mem [srdp_pkg::TableSize];
  logic [srdp_pkg::ValueW-1:0]    tbl_mem [srdp_pkg::TableSize];
  logic                           used_neg [srdp_pkg::TableSize];
  logic                           used_pos [srdp_pkg::TableSize];

  logic [AW-1:0]               ecol_q;
  logic [srdp_pkg::ValueW-1:0] eval_q, tbl_q;
  logic [srdp_pkg::CheckW-1:0] check_q, chk_wdata;
  logic                        used_n_q, used_p_q, used_hit;
  logic                        ebuf_we, chk_we, tbl_we, used_n_we, used_p_we, used_wdata;
  logic [AW-1:0]               chk_raddr, chk_waddr, used_addr, loc;
  logic                        last_k;

  assign loc_w    = j_q + $signed({2'b00, ecol_q});
  assign loc      = loc_w[AW-1:0];
  assign reach    = j_q + $signed({2'b00, max_q});
  assign used_hit = j_q[DW-1] ? used_n_q : used_p_q;
  assign last_k   = (k_q == count_q - CW'(1));
  assign used_addr = (state_q == SClear) ? clr_q : j_q[AW-1:0];

  assign ctrl_o.clearing = (state_q == SClear);
  assign ctrl_o.pop      = (state_q == SIdle) && q_valid_i;
  assign res_valid_o     = (state_q == SResult);
  assign res_o           = res_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    min_d     = min_q;
    max_d     = max_q;
    lowest_d  = lowest_q;
    highest_d = highest_q;
    clr_d     = clr_q;
    j_d       = j_q;
    res_d     = res_q;
    ebuf_we   = 1'b0;
    chk_we    = 1'b0;
    tbl_we    = 1'b0;
    used_n_we = 1'b0;
    used_p_we = 1'b0;
    used_wdata = 1'b0;
    chk_raddr = loc;
    chk_waddr = loc;
    chk_wdata = {1'b0, ecol_q};

    case (state_q)
      SClear: begin
        chk_we    = 1'b1;
        chk_waddr = clr_q;
        chk_wdata = srdp_pkg::CheckEmpty;
        used_n_we = 1'b1;
        used_p_we = 1'b1;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          lowest_d  = '0;
          highest_d = '0;
          state_d   = SIdle;
        end
      end
      SIdle: begin
        chk_raddr = q_item_i.column;
        if (q_valid_i) begin
          case (q_item_i.cmd)
            srdp_pkg::CmdLoad: begin
              if (count_q < CW'(srdp_pkg::MaxElem)) begin
                ebuf_we = 1'b1;
                count_d = count_q + CW'(1);
                if (count_q == '0 || q_item_i.column < min_q) min_d = q_item_i.column;
                if (count_q == '0 || q_item_i.column > max_q) max_d = q_item_i.column;
              end
              if (q_item_i.last) state_d = SStart;
            end
            srdp_pkg::CmdRead:  state_d = SRData;
            srdp_pkg::CmdClear: begin
              clr_d   = '0;
              state_d = SClear;
            end
            default: ;
          endcase
        end
      end
      SStart: begin
        j_d     = $signed({2'b00, lowest_q}) - $signed({2'b00, min_q});
        state_d = SJTest;
      end
      SJTest: begin
        if (reach >= TableLimit) begin
          res_d   = '{disp: '0, ovf: 1'b1, highest: highest_q, rvalue: '0, rcheck: '0,
                      is_read: 1'b0};
          count_d = '0;
          state_d = SResult;
        end else if (j_q == '0) begin
          j_d = j_q + DW'(1);
        end else begin
          k_d     = '0;
          state_d = SERead;
        end
      end
      SERead: state_d = SCRead;
      SCRead: state_d = SCTest;
      SCTest: begin
        if (check_q != srdp_pkg::CheckEmpty) begin
          j_d     = j_q + DW'(1);
          state_d = SJTest;
        end else if (last_k) begin
          if (used_hit) begin
            j_d     = j_q + DW'(1);
            state_d = SJTest;
          end else begin
            k_d     = '0;
            state_d = SWRead;
          end
        end else begin
          k_d     = k_q + CW'(1);
          state_d = SERead;
        end
      end
      SWRead: state_d = SWrite;
      SWrite: begin
        chk_we = 1'b1;
        tbl_we = 1'b1;
        if (loc > highest_q) highest_d = loc;
        if (last_k) begin
          used_wdata = 1'b1;
          used_n_we  = j_q[DW-1];
          used_p_we  = !j_q[DW-1];
          state_d    = SLfRead;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = SWRead;
        end
      end
      SLfRead: begin
        chk_raddr = lowest_q;
        state_d   = SLfTest;
      end
      SLfTest: begin
        if (lowest_q != LastAddr && check_q != srdp_pkg::CheckEmpty) begin
          lowest_d = lowest_q + AW'(1);
          state_d  = SLfRead;
        end else begin
          res_d   = '{disp: j_q[srdp_pkg::CheckW-1:0], ovf: 1'b0, highest: highest_q,
                      rvalue: '0, rcheck: '0, is_read: 1'b0};
          count_d = '0;
          state_d = SResult;
        end
      end
      SRData: begin
        res_d   = '{disp: '0, ovf: 1'b0, highest: highest_q,
                    rvalue: (check_q == srdp_pkg::CheckEmpty) ? '0 : tbl_q,
                    rcheck: check_q, is_read: 1'b1};
        state_d = SResult;
      end
      SResult: begin
        if (res_take_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      count_q   <= '0;
      lowest_q  <= '0;
      highest_q <= '0;
      clr_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      lowest_q  <= lowest_d;
      highest_q <= highest_d;
      clr_q     <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    min_q <= min_d;
    max_q <= max_d;
    j_q   <= j_d;
    res_q <= res_d;
  end

  // element buffer
  always_ff @(posedge clk_i) begin
    if (ebuf_we) begin
      ebuf_col[count_q[srdp_pkg::ElemIdxW-1:0]] <= q_item_i.column;
      ebuf_val[count_q[srdp_pkg::ElemIdxW-1:0]] <= q_item_i.value;
    end
    ecol_q <= ebuf_col[k_q[srdp_pkg::ElemIdxW-1:0]];
    eval_q <= ebuf_val[k_q[srdp_pkg::ElemIdxW-1:0]];
  end

  // check and value table
  always_ff @(posedge clk_i) begin
    if (chk_we) check_mem[chk_waddr] <= chk_wdata;
    if (tbl_we) tbl_mem[loc] <= eval_q;
    check_q <= check_mem[chk_raddr];
    tbl_q   <= tbl_mem[chk_raddr];
  end

  // used displacement flags, split by sign
  always_ff @(posedge clk_i) begin
    if (used_n_we) used_neg[used_addr] <= used_wdata;
    if (used_p_we) used_pos[used_addr] <= used_wdata;
    used_n_q <= used_neg[j_q[AW-1:0]];
    used_p_q <= used_pos[j_q[AW-1:0]];
  end

endmodule

FILE: rtl/sparse_row_displacement_packer.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | command_i column_i value_i last_element_i
// out     | output    | out_valid_o/out_stall_i | displacement_o overflow_o highest_position_o
//         |           |                         | read_value_o read_check_o is_read_reply_o
// A placement tests each candidate displacement against the check entry of every element
// and the used flags, writes each element, then steps the lowest free slot forward.
// After reset a clearing pass runs with in_stall_o high.
// A two-entry queue decouples input from the engine; the output register holds under stall.
module sparse_row_displacement_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [9:0]  column_i,
  input  logic [14:0] value_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] displacement_o,
  output logic        overflow_o,
  output logic [9:0]  highest_position_o,
  output logic [14:0] read_value_o,
  output logic [10:0] read_check_o,
  output logic        is_read_reply_o
);

  srdp_pkg::item_t      item, q_item;
  srdp_pkg::back_ctrl_t ctrl;
  srdp_pkg::result_t    res, out_q;
  logic                 q_valid, res_valid, res_take, out_valid_q, out_valid_d;

  assign item = '{cmd: command_i, column: column_i, value: value_i, last: last_element_i};

  srdp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .item_i   (item),
    .ctrl_i   (ctrl),
    .q_valid_o(q_valid),
    .q_item_o (q_item)
  );

  srdp_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .ctrl_o     (ctrl),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_take) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) out_q <= res;
  end

  assign out_valid_o        = out_valid_q;
  assign displacement_o     = out_q.disp;
  assign overflow_o         = out_q.ovf;
  assign highest_position_o = out_q.highest;
  assign read_value_o       = out_q.rvalue;
  assign read_check_o       = out_q.rcheck;
  assign is_read_reply_o    = out_q.is_read;

  a_ovf_no_disp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> displacement_o == '0)
    else $error("overflow result carries a displacement");

  a_place_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o && !is_read_reply_o |-> displacement_o != '0)
    else $error("placement chose displacement zero");

  a_read_no_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_read_reply_o |-> !overflow_o && displacement_o == '0)
    else $error("read reply carries placement fields");

  a_clear_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clearing |-> in_stall_o && !res_valid)
    else $error("input taken during clearing pass");

endmodule

FILE: verif/sparse_row_displacement_packer_test.sv
module sparse_row_displacement_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 4000000;
  localparam int HoldCycles = 3000;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = srdp_pkg::CmdRead;
  logic [9:0]  column_i = '0;
  logic [14:0] value_i = '0;
  logic        last_element_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [10:0] displacement_o;
  logic        overflow_o;
  logic [9:0]  highest_position_o;
  logic [14:0] read_value_o;
  logic [10:0] read_check_o;
  logic        is_read_reply_o;

  sparse_row_displacement_packer dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow of the packer state
  logic [srdp_pkg::AddrW-1:0]  pend_col[srdp_pkg::MaxElem];
  logic [srdp_pkg::ValueW-1:0] pend_val[srdp_pkg::MaxElem];
  int                          pend_count;
  logic [srdp_pkg::ValueW-1:0] shadow_table[srdp_pkg::TableSize];
  int                          shadow_check[srdp_pkg::TableSize];
  bit                          disp_taken[2*srdp_pkg::TableSize];
  int                          free_slot;
  int                          top_slot;

  srdp_pkg::result_t pending_results[$];
  int                errors = 0;
  int                beats_in = 0;
  int                idle_cycles = 0;
  bit                pinned_on = 1'b0;
  srdp_pkg::result_t pinned;

  task automatic wipe_table();
    for (int i = 0; i < srdp_pkg::TableSize; i++) begin
      shadow_table[i] = '0;
      shadow_check[i] = -1;
    end
    for (int i = 0; i < 2*srdp_pkg::TableSize; i++) disp_taken[i] = 1'b0;
    free_slot = 0;
    top_slot = 0;
  endtask

  // Search displacements upward; returns 1 and the displacement on a fit
  function automatic bit find_displacement(output int disp);
    int lo;
    int hi;
    bit ok;
    lo = 1 << 30;
    hi = -1;
    disp = 0;
    for (int k = 0; k < pend_count; k++) begin
      if (int'(pend_col[k]) < lo) lo = pend_col[k];
      if (int'(pend_col[k]) > hi) hi = pend_col[k];
    end
    if (pend_count == 0) return 1'b0;
    for (int j = free_slot - lo; ; j++) begin
      if (j + hi >= srdp_pkg::TableSize) return 1'b0;
      if (j != 0) begin
        ok = 1'b1;
        for (int k = 0; ok && k < pend_count; k++)
          if (shadow_check[j + int'(pend_col[k])] != -1) ok = 1'b0;
        if (ok && disp_taken[j + srdp_pkg::TableSize]) ok = 1'b0;
        if (ok) begin
          for (int k = 0; k < pend_count; k++) begin
            shadow_table[j + int'(pend_col[k])] = pend_val[k];
            shadow_check[j + int'(pend_col[k])] = pend_col[k];
            if (j + int'(pend_col[k]) > top_slot) top_slot = j + int'(pend_col[k]);
          end
          disp_taken[j + srdp_pkg::TableSize] = 1'b1;
          while (free_slot < srdp_pkg::TableSize - 1 && shadow_check[free_slot] != -1)
            free_slot++;
          disp = j;
          return 1'b1;
        end
      end
    end
  endfunction

  task automatic predict_beat(input logic [1:0] cmd, input logic [9:0] col,
                              input logic [14:0] val, input logic last,
                              output bit has_res, output srdp_pkg::result_t res);
    int  disp;
    bit  fits;
    res = '0;
    has_res = 1'b0;
    if (cmd == srdp_pkg::CmdLoad) begin
      if (pend_count < srdp_pkg::MaxElem) begin
        pend_col[pend_count] = col;
        pend_val[pend_count] = val;
        pend_count++;
      end
      if (last) begin
        fits = find_displacement(disp);
        pend_count = 0;
        res.disp = fits ? srdp_pkg::CheckW'(disp) : '0;
        res.ovf = !fits;
        res.highest = srdp_pkg::AddrW'(top_slot);
        has_res = 1'b1;
      end
    end else if (cmd == srdp_pkg::CmdRead) begin
      res.highest = srdp_pkg::AddrW'(top_slot);
      res.rvalue = shadow_table[col];
      res.rcheck = srdp_pkg::CheckW'(shadow_check[col]);
      res.is_read = 1'b1;
      has_res = 1'b1;
    end else if (cmd == srdp_pkg::CmdClear) begin
      wipe_table();
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check results and predict on accepted input beats
  always @(posedge clk_i) begin
    bit                has_res;
    srdp_pkg::result_t res;
    srdp_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (displacement_o != want.disp) report("displacement", displacement_o, want.disp);
          if (overflow_o != want.ovf) report("overflow", overflow_o, want.ovf);
          if (highest_position_o != want.highest)
            report("highest_position", highest_position_o, want.highest);
          if (read_value_o != want.rvalue) report("read_value", read_value_o, want.rvalue);
          if (read_check_o != want.rcheck) report("read_check", read_check_o, want.rcheck);
          if (is_read_reply_o != want.is_read)
            report("is_read_reply", is_read_reply_o, want.is_read);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_beat(command_i, column_i, value_i, last_element_i, has_res, res);
        if (has_res) pending_results.push_back(pinned_on ? pinned : res);
        beats_in++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("sparse_row_displacement_packer test failed");
        $finish;
      end
    end
  end

  // Receiver: random stall pattern, stall-free stretches, plus one long hold-off
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && beats_in >= 400) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if ((beats_in / 97) % 3 == 1) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 35);
      end
    end
  end

  int burst_left = 0;

  task automatic send(input logic [1:0] cmd, input logic [9:0] col,
                      input logic [14:0] val, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i = 1'b1;
    command_i = cmd;
    column_i = col;
    value_i = val;
    last_element_i = last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    pinned_on = 1'b0;
  endtask

  typedef struct {
    logic [1:0]        cmd;
    logic [9:0]        col;
    logic [14:0]       val;
    logic              last;
    bit                typed;
    srdp_pkg::result_t res;
  } row_t;

  localparam srdp_pkg::result_t EmptyRead = '{disp: '0, ovf: 1'b0, highest: '0, rvalue: '0,
                                              rcheck: srdp_pkg::CheckEmpty, is_read: 1'b1};
  localparam srdp_pkg::result_t Unused = '0;

  row_t plan[] = '{
    '{srdp_pkg::CmdRead, 10'd0, 15'd0, 1'b0, 1'b1, EmptyRead},
    '{srdp_pkg::CmdRead, 10'd1023, 15'h7fff, 1'b1, 1'b1, EmptyRead},
    '{CmdUnused, 10'd1023, 15'h7fff, 1'b1, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd0, 15'h7fff, 1'b1, 1'b1,
      '{disp: 11'd1, ovf: 1'b0, highest: 10'd1, rvalue: '0, rcheck: '0, is_read: 1'b0}},
    '{srdp_pkg::CmdRead, 10'd1, 15'd0, 1'b0, 1'b1,
      '{disp: '0, ovf: 1'b0, highest: 10'd1, rvalue: 15'h7fff, rcheck: '0, is_read: 1'b1}},
    '{srdp_pkg::CmdLoad, 10'd1023, 15'd0, 1'b1, 1'b1,
      '{disp: 11'h401, ovf: 1'b0, highest: 10'd1, rvalue: '0, rcheck: '0, is_read: 1'b0}},
    '{srdp_pkg::CmdRead, 10'd0, 15'd0, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd0, 15'd5, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd1023, 15'd6, 1'b1, 1'b0, Unused},
    '{srdp_pkg::CmdClear, 10'd0, 15'd0, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdRead, 10'd1, 15'd0, 1'b0, 1'b1, EmptyRead},
    '{srdp_pkg::CmdLoad, 10'd1023, 15'h2aaa, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd5, 15'h5555, 1'b1, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd3, 15'd1, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd3, 15'd2, 1'b1, 1'b0, Unused},
    '{srdp_pkg::CmdRead, 10'd3, 15'd0, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd700, 15'd9, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdClear, 10'd0, 15'd0, 1'b1, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd701, 15'd10, 1'b1, 1'b0, Unused},
    '{srdp_pkg::CmdRead, 10'd701, 15'd0, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd0, 15'd1, 1'b0, 1'b0, Unused},
    '{srdp_pkg::CmdLoad, 10'd1023, 15'd2, 1'b1, 1'b0, Unused},
    '{srdp_pkg::CmdRead, 10'd1023, 15'd0, 1'b0, 1'b0, Unused}
  };

  initial begin
    int n;
    int base;
    int spread;
    int pick;
    pend_count = 0;
    wipe_table();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      pinned_on = plan[i].typed;
      pinned = plan[i].res;
      send(plan[i].cmd, plan[i].col, plan[i].val, plan[i].last);
    end

    // Overfill the element buffer; the final element is dropped but its last flag still starts a placement
    for (int i = 0; i < srdp_pkg::MaxElem + 8; i++)
      send(srdp_pkg::CmdLoad, 10'(i * 3), 15'($urandom), i == srdp_pkg::MaxElem + 7);
    send(srdp_pkg::CmdRead, 10'd9, 15'd0, 1'b0);
    send(srdp_pkg::CmdClear, 10'd0, 15'd0, 1'b0);

    n = 0;
    while (n < 700) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send(srdp_pkg::CmdClear, 10'($urandom), 15'($urandom), 1'($urandom));
        n++;
      end else if (pick < 15) begin
        send(srdp_pkg::CmdRead, 10'($urandom), 15'($urandom), 1'($urandom));
        n++;
      end else if (pick < 17) begin
        send(CmdUnused, 10'($urandom), 15'($urandom), 1'($urandom));
      end else begin
        spread = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 31);
        base = $urandom_range(0, 1023 - spread);
        pick = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int k = 0; k < pick; k++) begin
          send(srdp_pkg::CmdLoad, 10'(base + $urandom_range(0, spread)), 15'($urandom),
               k == pick - 1);
          n++;
        end
      end
    end
    in_valid_i = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4000) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("sparse_row_displacement_packer test passed");
    end else begin
      $display("sparse_row_displacement_packer test failed");
    end
    $finish;
  end

endmodule
